FILE: rtl/mlscr_pkg.sv
// ----------------------------------------------------------------------------
// mlscr_pkg
// Shared types and constants for the multi-line settle change reporter.
// ----------------------------------------------------------------------------
`default_nettype none

package mlscr_pkg;

  // defaults for the top-level parameters
  localparam int NUM_LINES_DEF = 32;
  localparam int AGE_BITS_DEF  = 16;

  // field widths fixed by the item format
  localparam int CMD_W      = 2;
  localparam int LINE_W     = 5;
  localparam int SETTLE_W   = 16;
  localparam int LINES_W    = 6;
  localparam int LINE_CNT_W = 7;   // holds a line count up to 127
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  // at most this many reports per tick
  localparam int MAX_REPORTS = 32;
  localparam int RPT_CNT_W   = $clog2(MAX_REPORTS + 1);

  // register reset values
  localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd100;
  localparam logic [LINES_W-1:0]  LINES_RESET  = 6'd32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESYNC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_SETTLE = 2'd0;
  localparam logic [1:0] REG_INVERT = 2'd1;
  localparam logic [1:0] REG_LINES  = 2'd2;

  typedef struct packed {
    logic [SETTLE_W-1:0] settle;
    logic                invert;
    logic [LINES_W-1:0]  lines;
  } cfg_t;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic              occ;
  } rpt_t;

  typedef struct packed {
    logic can_push;     // a new report can be taken this cycle
    logic pend_empty;   // no report held back
  } oq_stat_t;

endpackage

`default_nettype wire

FILE: rtl/mlscr_if.sv
// ----------------------------------------------------------------------------
// mlscr_if
// Valid/ready channels for input items and report items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlscr_in_if;
  import mlscr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [LINE_W-1:0] line;
  logic              edge_rising;
  logic              level;
  logic              link_up;

  modport source (output valid, command, line, edge_rising, level, link_up,
                  input ready);
  modport sink   (input valid, command, line, edge_rising, level, link_up,
                  output ready);
endinterface

interface mlscr_out_if;
  import mlscr_pkg::*;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] report_line;
  logic              occupied;
  logic              last;

  modport source (output valid, report_line, occupied, last, input ready);
  modport sink   (input valid, report_line, occupied, last, output ready);
endinterface

`default_nettype wire

FILE: rtl/mlscr_ram.sv
// ----------------------------------------------------------------------------
// mlscr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mlscr_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mlscr_cfg.sv
// ----------------------------------------------------------------------------
// mlscr_cfg
// APB register file: settle limit, invert, lines in use.
// ----------------------------------------------------------------------------
`default_nettype none

module mlscr_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mlscr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [mlscr_pkg::PDATA_W-1:0]   pwdata,
  output logic      [mlscr_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready,
  output mlscr_pkg::cfg_t                      cfg
);
  import mlscr_pkg::*;

  logic [SETTLE_W-1:0] settle_r;
  logic                invert_r;
  logic [LINES_W-1:0]  lines_r;
  logic [1:0]          reg_idx;
  logic                wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RESET;
      invert_r <= 1'b0;
      lines_r  <= LINES_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SETTLE: settle_r <= pwdata[SETTLE_W-1:0];
        REG_INVERT: invert_r <= pwdata[0];
        REG_LINES:  lines_r  <= pwdata[LINES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SETTLE: prdata = PDATA_W'(settle_r);
      REG_INVERT: prdata = PDATA_W'(invert_r);
      REG_LINES:  prdata = PDATA_W'(lines_r);
      default:    prdata = '0;
    endcase
  end

  assign cfg.settle = settle_r;
  assign cfg.invert = invert_r;
  assign cfg.lines  = lines_r;

endmodule

`default_nettype wire

FILE: rtl/mlscr_outq.sv
// ----------------------------------------------------------------------------
// mlscr_outq
// Report staging: holds one report back until the next one (or the end of
// the scan) decides its last flag, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mlscr_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  mlscr_pkg::rpt_t        push_rpt,
  input  wire logic              flush,
  output mlscr_pkg::oq_stat_t    stat,
  mlscr_out_if.source            out_chan
);
  import mlscr_pkg::*;

  logic              pend_v_r, pend_v_nxt;
  rpt_t              pend_r;
  logic              out_v_r, out_v_nxt;
  rpt_t              out_rpt_r;
  logic              out_last_r;
  logic              out_free;
  logic              load_mid;
  logic              load_last;

  assign out_free  = !out_v_r || out_chan.ready;
  assign load_mid  = push && pend_v_r;
  assign load_last = flush && !push && pend_v_r && out_free;

  always_comb begin
    out_v_nxt = out_v_r;
    if (load_mid || load_last) begin
      out_v_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_v_nxt = 1'b0;
    end
    pend_v_nxt = pend_v_r;
    if (push) begin
      pend_v_nxt = 1'b1;
    end else if (load_last) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_mid || load_last) begin
      out_rpt_r  <= pend_r;
      out_last_r <= load_last;
    end
    if (push) begin
      pend_r <= push_rpt;
    end
  end

  assign stat.can_push   = !pend_v_r || out_free;
  assign stat.pend_empty = !pend_v_r;

  assign out_chan.valid       = out_v_r;
  assign out_chan.report_line = out_rpt_r.line;
  assign out_chan.occupied    = out_rpt_r.occ;
  assign out_chan.last        = out_last_r;

endmodule

`default_nettype wire

FILE: rtl/multi_line_settle_change_reporter.sv
// ----------------------------------------------------------------------------
// multi_line_settle_change_reporter
// Per-line occupancy qualifier: settles edge/resync activity and reports
// changed lines on tick items.
// ----------------------------------------------------------------------------
// Usage:
//  - in_chan (valid/ready) carries items: edge event, resync level or tick.
//  - out_chan (valid/ready) carries one report per settled line change;
//    last marks the final report caused by a tick.
//  - APB port (psel..pready) writes settle_ticks, invert_logic and
//    lines_in_use; write it only while the block is idle.
//  - Per-line state (seen, reported, age) lives in one RAM with a registered
//    read. Edge item: read, then write back. Resync item: blind write.
//    Tick item: take it, then per active line a read and then a modify and
//    write back, then release of the final report (with no active lines
//    only the take); the line scan is the bound on throughput.
//  - A report is held one step so its last flag is known, then goes to the
//    output register; new items are taken while that register waits.
//  - If the receiver stalls, the scan pauses on the current line until the
//    staging slot frees; no report is dropped.
//  - Reset: registers go to their defaults, a valid bit per line is cleared,
//    and a line that was never written reads as clear/unreported with a
//    saturated age. No clearing pass is needed; items are taken at once.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_line_settle_change_reporter #(
  parameter int NUM_LINES = mlscr_pkg::NUM_LINES_DEF,
  parameter int AGE_BITS  = mlscr_pkg::AGE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  mlscr_in_if.sink                             in_chan,
  mlscr_out_if.source                          out_chan,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mlscr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [mlscr_pkg::PDATA_W-1:0]   pwdata,
  output logic      [mlscr_pkg::PDATA_W-1:0]   prdata,
  output logic                                 pready
);
  import mlscr_pkg::*;

  localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
  localparam int ENT_W = AGE_BITS + 2;           // {seen, reported, age}
  localparam int CMP_W = (AGE_BITS > SETTLE_W) ? AGE_BITS : SETTLE_W;
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EDGE  = 5'b00010,
    S_RD    = 5'b00100,
    S_MOD   = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t                  state_r, state_nxt;
  cfg_t                    cfg;
  oq_stat_t                oq_stat;

  // per-item working registers
  logic [IDX_W-1:0]        idx_r, idx_nxt;       // scan index or edge target
  logic                    op_bit_r, op_bit_nxt; // new seen bit for an edge
  logic                    link_r, link_nxt;
  logic [LINE_CNT_W-1:0]   n_r, n_nxt;
  logic [RPT_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NUM_LINES-1:0]    vld_r, vld_nxt;
  logic                    rd_vld_r;

  // RAM ports
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [ENT_W-1:0]        ram_wdata, ram_rdata;

  // decode of the current item and entry
  logic [LINE_CNT_W-1:0]   n_eff;
  logic [IDX_W+LINE_W-1:0] ln_wide;
  logic [IDX_W-1:0]        in_addr;
  logic                    ln_hit;
  logic                    in_acc;
  logic                    in_bit;
  logic [ENT_W-1:0]        cur;
  logic                    cur_seen, cur_rep;
  logic [AGE_BITS-1:0]     cur_age, new_age;
  logic                    due;
  logic                    can_go;
  logic                    last_line;
  logic [IDX_W+LINE_W-1:0] idx_wide;
  rpt_t                    push_rpt;
  logic                    push;
  logic                    flush;

  mlscr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mlscr_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_LINES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mlscr_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rpt (push_rpt),
    .flush    (flush),
    .stat     (oq_stat),
    .out_chan (out_chan)
  );

  // effective line count: lines_in_use capped at NUM_LINES
  assign n_eff = (LINE_CNT_W'(cfg.lines) > LINE_CNT_W'(NUM_LINES)) ?
                 LINE_CNT_W'(NUM_LINES) : LINE_CNT_W'(cfg.lines);

  assign ln_wide  = (IDX_W + LINE_W)'(in_chan.line);
  assign in_addr  = ln_wide[IDX_W-1:0];
  assign ln_hit   = LINE_CNT_W'(in_chan.line) < n_eff;
  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign in_bit   = (in_chan.command == CMD_EDGE) ? in_chan.edge_rising ^ cfg.invert
                                                  : in_chan.level ^ cfg.invert;

  // unwritten entries read as reset value
  assign cur      = rd_vld_r ? ram_rdata : {1'b0, 1'b0, AGE_MAX};
  assign cur_seen = cur[ENT_W-1];
  assign cur_rep  = cur[ENT_W-2];
  assign cur_age  = cur[AGE_BITS-1:0];

  // tick: age first (saturating), then test for a due report
  assign new_age  = (cur_age == AGE_MAX) ? cur_age : cur_age + AGE_BITS'(1);
  assign due      = link_r && (cur_seen != cur_rep) &&
                    (CMP_W'(new_age) > CMP_W'(cfg.settle)) &&
                    (cnt_r < RPT_CNT_W'(MAX_REPORTS));
  assign can_go    = !due || oq_stat.can_push;
  assign last_line = (LINE_CNT_W'(idx_r) + LINE_CNT_W'(1)) == n_r;

  assign idx_wide      = (IDX_W + LINE_W)'(idx_r);
  assign push_rpt.line = idx_wide[LINE_W-1:0];
  assign push_rpt.occ  = cur_seen;
  assign push          = (state_r == S_MOD) && due && oq_stat.can_push;
  assign flush         = (state_r == S_FLUSH);

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    op_bit_nxt = op_bit_r;
    link_nxt   = link_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = idx_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_chan.command)
            CMD_EDGE: begin
              if (ln_hit) begin
                // need the reported bit back: read now, write next cycle
                ram_re     = 1'b1;
                ram_raddr  = in_addr;
                idx_nxt    = in_addr;
                op_bit_nxt = in_bit;
                state_nxt  = S_EDGE;
              end
            end
            CMD_RESYNC: begin
              if (ln_hit) begin
                // every field is known: blind write, age saturated so due once above settle
                ram_we    = 1'b1;
                ram_waddr = in_addr;
                ram_wdata = {in_bit, ~in_bit, AGE_MAX};
              end
            end
            CMD_TICK: begin
              link_nxt = in_chan.link_up;
              n_nxt    = n_eff;
              cnt_nxt  = '0;
              idx_nxt  = '0;
              if (n_eff != '0) begin
                state_nxt = S_RD;
              end
            end
            default: ;
          endcase
        end
      end
      S_EDGE: begin
        ram_we    = 1'b1;
        ram_wdata = {op_bit_r, cur_rep, {AGE_BITS{1'b0}}};
        state_nxt = S_IDLE;
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        // read data holds while stalled (no new read issued)
        if (can_go) begin
          ram_we    = 1'b1;
          ram_wdata = {cur_seen, due ? cur_seen : cur_rep, new_age};
          if (due) begin
            cnt_nxt = cnt_r + RPT_CNT_W'(1);
          end
          if (last_line) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt   = idx_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_FLUSH: begin
        if (oq_stat.can_push) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    vld_nxt = vld_r;
    if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vld_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    op_bit_r <= op_bit_nxt;
    link_r   <= link_nxt;
    n_r      <= n_nxt;
    if (ram_re) begin
      rd_vld_r <= vld_r[ram_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> oq_stat.pend_empty)
    else $error("held report left behind after tick scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> (LINE_CNT_W'(idx_r) < n_r))
    else $error("scan index beyond active line count");

  a_report_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RPT_CNT_W'(MAX_REPORTS))
    else $error("report count exceeds per-tick cap");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MOD) && !can_go) |=> ((state_r == S_MOD) && $stable(idx_r)))
    else $error("scan advanced while report slot was busy");

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-line settle change reporter. Drives
// edge, resync and tick items over the valid/ready input channel and
// programs the APB registers. A line-level model predicts every report.
// A monitor compares each accepted report, field by field and in order,
// with the oldest expected one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlscr_pkg::*;

  localparam int NLINES = NUM_LINES_DEF;
  localparam logic [AGE_BITS_DEF-1:0] AGE_SAT = '1;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;  // decoded as no-op
  // a tick scans every line (read, then modify) plus release; margin on top
  localparam int SCAN_CYCLES = 2 * NLINES + 40;
  localparam int DRAIN_LIMIT = 50000;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic              occ;
    logic              last;
  } report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // APB side
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mlscr_in_if  in_if ();
  mlscr_out_if out_if ();

  multi_line_settle_change_reporter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Line model: shadow registers plus per-line seen/reported/age.
  // --------------------------------------------------------------------------
  logic [SETTLE_W-1:0]     shadow_settle;
  logic                    shadow_invert;
  logic [LINES_W-1:0]      shadow_lines;
  logic                    occ_seen     [NLINES];
  logic                    occ_reported [NLINES];
  logic [AGE_BITS_DEF-1:0] line_age     [NLINES];

  report_t expected_reports [$];

  int fail_count      = 0;
  int items_sent      = 0;
  int ticks_sent      = 0;
  int reports_checked = 0;

  // idle percentages, changed per phase
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;

  function automatic int active_lines();
    return (shadow_lines > NLINES) ? NLINES : int'(shadow_lines);
  endfunction

  function automatic void reset_line_model();
    shadow_settle = SETTLE_RESET;
    shadow_invert = 1'b0;
    shadow_lines  = LINES_RESET;
    for (int i = 0; i < NLINES; i++) begin
      occ_seen[i]     = 1'b0;
      occ_reported[i] = 1'b0;
      line_age[i]     = AGE_SAT;
    end
    expected_reports.delete();
  endfunction

  // Apply one accepted item to the model and queue the reports it causes.
  function automatic void predict_reports(logic [CMD_W-1:0] cmd, logic [LINE_W-1:0] ln,
                                          logic rising, logic lvl, logic link);
    int      n;
    int      count;
    logic    s;
    logic    have_prev;
    report_t prev;
    n         = active_lines();
    count     = 0;
    have_prev = 1'b0;
    prev      = '0;
    case (cmd)
      CMD_EDGE: begin
        if (int'(ln) < n) begin
          occ_seen[ln] = rising ^ shadow_invert;
          line_age[ln] = '0;
        end
      end
      CMD_RESYNC: begin
        if (int'(ln) < n) begin
          s                = lvl ^ shadow_invert;
          occ_seen[ln]     = s;
          occ_reported[ln] = ~s;
          line_age[ln]     = AGE_SAT;  // saturated age: due when above settle
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < n; i++)
          if (line_age[i] != AGE_SAT) line_age[i] = line_age[i] + 1'b1;
        if (link) begin
          // hold each report back one step so the final one gets last
          for (int i = 0; i < n && count < MAX_REPORTS; i++) begin
            if (occ_seen[i] != occ_reported[i] && line_age[i] > shadow_settle) begin
              if (have_prev) expected_reports.push_back(prev);
              prev.line       = LINE_W'(i);
              prev.occ        = occ_seen[i];
              prev.last       = 1'b0;
              have_prev       = 1'b1;
              occ_reported[i] = occ_seen[i];
              count++;
            end
          end
          if (have_prev) begin
            prev.last = 1'b1;
            expected_reports.push_back(prev);
          end
        end
      end
      default: ;  // unused command: nothing changes
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  report_t seen_report;
  report_t oldest_report;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      seen_report = '{line: out_if.report_line, occ: out_if.occupied, last: out_if.last};
      if (expected_reports.size() == 0) begin
        report_mismatch("report with none expected, line", int'(seen_report.line), -1);
      end else begin
        oldest_report = expected_reports.pop_front();
        if (seen_report.line != oldest_report.line)
          report_mismatch("report_line", int'(seen_report.line), int'(oldest_report.line));
        if (seen_report.occ != oldest_report.occ)
          report_mismatch("occupied", int'(seen_report.occ), int'(oldest_report.occ));
        if (seen_report.last != oldest_report.last)
          report_mismatch("last", int'(seen_report.last), int'(oldest_report.last));
        reports_checked++;
      end
    end
  end

  // receiver: ready changes on the falling edge
  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= rcv_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Send one item; valid stays high afterwards so back-to-back items flow.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [LINE_W-1:0] ln,
                           logic rising, logic lvl, logic link);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      in_if.valid = 1'b0;
    end
    @(negedge clk);
    in_if.valid       = 1'b1;
    in_if.command     = cmd;
    in_if.line        = ln;
    in_if.edge_rising = rising;
    in_if.level       = lvl;
    in_if.link_up     = link;
    do @(posedge clk); while (!in_if.ready);
    predict_reports(cmd, ln, rising, lvl, link);
    items_sent++;
    if (cmd == CMD_TICK) ticks_sent++;
  endtask

  // Drop valid, wait for every expected report, then let a last scan finish.
  task automatic drain_reports();
    int waited;
    waited = 0;
    @(negedge clk);
    in_if.valid = 1'b0;
    while (expected_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_reports.size() != 0) begin
      report_mismatch("reports never delivered", 0, expected_reports.size());
      expected_reports.delete();
    end
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] want;
    logic [PDATA_W-1:0] got;
    case (idx)
      REG_SETTLE: want = PDATA_W'(value[SETTLE_W-1:0]);
      REG_INVERT: want = PDATA_W'(value[0]);
      default:    want = PDATA_W'(value[LINES_W-1:0]);
    endcase
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SETTLE: shadow_settle = value[SETTLE_W-1:0];
      REG_INVERT: shadow_invert = value[0];
      default:    shadow_lines  = value[LINES_W-1:0];
    endcase
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got != want) report_mismatch("register read-back", int'(got), int'(want));
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Defaults: settle 100, all 32 lines, no inversion.
  task automatic test_reset_defaults();
    send_item(CMD_RESYNC, 5'd0, 1'b0, 1'b1, 1'b0);  // due at once
    send_item(CMD_TICK,   5'd0, 1'b0, 1'b0, 1'b0);  // link down: ages only
    send_item(CMD_TICK,   5'd0, 1'b0, 1'b0, 1'b1);  // line 0 reported
    send_item(CMD_EDGE,   5'd3, 1'b1, 1'b0, 1'b0);
    send_item(CMD_TICK,   5'd0, 1'b0, 1'b0, 1'b1);  // age 1, not settled
    drain_reports();
  endtask

  // Zero settle: one tick after an edge is enough; lowest and highest lines.
  task automatic test_edges_settle_zero();
    write_reg(REG_SETTLE, 32'd0);
    send_item(CMD_EDGE,   5'd31, 1'b1, 1'b0, 1'b0);
    send_item(CMD_EDGE,   5'd0,  1'b0, 1'b1, 1'b1);
    send_item(CMD_UNUSED, 5'd31, 1'b1, 1'b1, 1'b1);  // no-op command
    send_item(CMD_TICK,   5'd31, 1'b1, 1'b1, 1'b1);
    send_item(CMD_EDGE,   5'd5,  1'b1, 1'b0, 1'b0);
    send_item(CMD_TICK,   5'd0,  1'b0, 1'b0, 1'b0);
    send_item(CMD_TICK,   5'd0,  1'b0, 1'b0, 1'b1);
    drain_reports();
  endtask

  // Inverted sense for edges and levels.
  task automatic test_invert();
    write_reg(REG_INVERT, 32'd1);
    send_item(CMD_EDGE,   5'd7, 1'b1, 1'b0, 1'b0);
    send_item(CMD_EDGE,   5'd8, 1'b0, 1'b0, 1'b0);
    send_item(CMD_RESYNC, 5'd9, 1'b0, 1'b0, 1'b0);
    send_item(CMD_TICK,   5'd0, 1'b0, 1'b0, 1'b1);
    drain_reports();
  endtask

  // Line count of zero, one, and above the line total.
  task automatic test_line_count();
    write_reg(REG_LINES, 32'd0);
    send_item(CMD_EDGE,   5'd0, 1'b1, 1'b0, 1'b0);  // ignored
    send_item(CMD_RESYNC, 5'd1, 1'b0, 1'b1, 1'b0);  // ignored
    send_item(CMD_TICK,   5'd0, 1'b0, 1'b0, 1'b1);
    drain_reports();
    write_reg(REG_LINES, 32'd1);
    send_item(CMD_EDGE,   5'd1, 1'b0, 1'b0, 1'b0);  // beyond count
    send_item(CMD_EDGE,   5'd0, 1'b0, 1'b0, 1'b0);
    send_item(CMD_TICK,   5'd0, 1'b0, 1'b0, 1'b1);
    drain_reports();
    write_reg(REG_LINES, 32'd63);  // capped at the line total
    send_item(CMD_EDGE,   5'd31, 1'b1, 1'b0, 1'b0);
    send_item(CMD_TICK,   5'd0,  1'b0, 1'b0, 1'b1);
    drain_reports();
  endtask

  // Settle at the saturated age blocks reports; one below lets them out.
  task automatic test_settle_extremes();
    write_reg(REG_SETTLE, 32'hFFFF);
    send_item(CMD_RESYNC, 5'd2, 1'b0, 1'b0, 1'b0);
    send_item(CMD_TICK,   5'd0, 1'b0, 1'b0, 1'b1);
    drain_reports();
    write_reg(REG_SETTLE, 32'd65534);
    send_item(CMD_TICK,   5'd0, 1'b0, 1'b0, 1'b1);
    drain_reports();
  endtask

  // --------------------------------------------------------------------------
  // Random phase: mostly edge/resync bursts followed by tick runs, some noise.
  // --------------------------------------------------------------------------
  task automatic test_random_phase(int snd_pct, int rcv_pct, int n_items);
    int pick;
    int n;
    int target;
    int burst;
    drain_reports();
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    // small settle values so reports actually come out
    pick = $urandom_range(9);
    write_reg(REG_SETTLE, (pick == 0) ? 32'd40 : 32'($urandom_range(3)));
    write_reg(REG_INVERT, 32'($urandom_range(1)));
    pick = $urandom_range(9);
    if (pick == 0)      write_reg(REG_LINES, 32'($urandom_range(63, 33)));
    else if (pick == 1) write_reg(REG_LINES, 32'd32);
    else                write_reg(REG_LINES, 32'($urandom_range(32, 1)));
    n      = active_lines();
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        // every active line due at once: a full-length report train
        for (int i = 0; i < n; i++)
          send_item(CMD_RESYNC, LINE_W'(i), 1'($urandom), 1'($urandom), 1'($urandom));
        send_item(CMD_TICK, 5'($urandom), 1'($urandom), 1'($urandom), 1'b1);
      end else if (pick < 80) begin
        burst = $urandom_range(6, 1);
        for (int i = 0; i < burst; i++) begin
          send_item(($urandom_range(3) == 0) ? CMD_RESYNC : CMD_EDGE,
                    (n > 0) ? LINE_W'($urandom_range(n - 1)) : 5'($urandom),
                    1'($urandom), 1'($urandom), 1'($urandom));
        end
        burst = $urandom_range(5, 1);
        for (int i = 0; i < burst; i++)
          send_item(CMD_TICK, 5'($urandom), 1'($urandom), 1'($urandom),
                    ($urandom_range(9) != 0));
      end else begin
        // any command including the unused one, any line
        send_item(CMD_W'($urandom), 5'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom));
      end
    end
    drain_reports();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid       = 1'b0;
    in_if.command     = CMD_EDGE;
    in_if.line        = '0;
    in_if.edge_rising = 1'b0;
    in_if.level       = 1'b0;
    in_if.link_up     = 1'b0;
    out_if.ready      = 1'b0;
    reset_line_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part with light back-pressure
    snd_idle_pct = 14;
    rcv_idle_pct = 51;
    test_reset_defaults();
    test_edges_settle_zero();
    test_invert();
    test_line_count();
    test_settle_extremes();

    // random part: sender-light, receiver-light, then full rate
    test_random_phase(14, 51, 60);
    test_random_phase(51, 14, 60);
    test_random_phase(0, 0, 60);

    $display("Summary: %0d items (%0d ticks) sent, %0d reports checked, %0d errors",
             items_sent, ticks_sent, reports_checked, fail_count);
    $display("Covered: defaults, settle 0/65534/65535, inversion, line counts 0/1/63");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
